/* design/nlsc_pkg.sv */
// ----------------------------------------------------------------------------
// nlsc_pkg
// Shared types and constants of the name list checker: words on both
// channels, the parser phase, error codes, special characters and the
// command that the parser sends to the row of name cells.
// ----------------------------------------------------------------------------
package nlsc_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic       done_res;
    logic       accepted;
    logic [3:0] error_code;
    logic [4:0] name_count;
    logic       name_done;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_PRE,
    PH_OPEN,
    PH_QUOTE,
    PH_NAME,
    PH_AFTER,
    PH_TAIL
  } phase_t;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_EMPTY     = 4'd1;
  localparam logic [3:0] ERR_NO_OPEN   = 4'd2;
  localparam logic [3:0] ERR_NO_QUOTE  = 4'd3;
  localparam logic [3:0] ERR_UNCLOSED  = 4'd4;
  localparam logic [3:0] ERR_BAD_NAME  = 4'd5;
  localparam logic [3:0] ERR_DUPLICATE = 4'd6;
  localparam logic [3:0] ERR_NO_SEP    = 4'd7;
  localparam logic [3:0] ERR_TRAILING  = 4'd8;
  localparam logic [3:0] ERR_OVERFLOW  = 4'd9;

  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_DASH     = 8'h2d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;

  // command broadcast to every name cell
  typedef struct packed {
    logic       clear;
    logic       open;
    logic       cmp;
    logic       commit;
    logic [7:0] ch;
  } cell_cmd_t;

endpackage

/* design/nlsc_cell.sv */
// ----------------------------------------------------------------------------
// nlsc_cell
// One stored name slot: byte memory, length, occupied bit and running match
// flag. The occupied bit and the duplicate hit ripple on to the next cell.
// ----------------------------------------------------------------------------
module nlsc_cell #(
  parameter int MAX_NAME_LEN = 32,
  parameter int LW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nlsc_pkg::cell_cmd_t cmd,
  input  logic [LW-1:0]       cur_len,
  input  logic [LW-1:0]       rd_len,
  input  logic                prev_active,
  output logic                active_out,
  input  logic                dup_in,
  output logic                dup_out
);
  import nlsc_pkg::*;

  localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

  logic [7:0]    mem [MAX_NAME_LEN];
  logic [7:0]    rd_r;
  logic [LW-1:0] slen_r;
  logic          active_r;
  logic          match_r;
  logic          target;
  logic [AW-1:0] rd_addr;
  logic          miss;

  assign target     = prev_active && !active_r;
  assign active_out = active_r;
  assign rd_addr    = (rd_len < LW'(MAX_NAME_LEN)) ? rd_len[AW-1:0] : '0;
  assign miss       = (cur_len >= slen_r) || (rd_r != cmd.ch);
  assign dup_out    = dup_in || (active_r && match_r && (slen_r == cur_len));

  // byte store, read one position ahead
  always_ff @(posedge clk) begin
    if (cmd.cmp && target) begin
      mem[cur_len[AW-1:0]] <= cmd.ch;
    end
    rd_r <= mem[rd_addr];
    if (cmd.commit && target) begin
      slen_r <= cur_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      active_r <= 1'b0;
      match_r  <= 1'b1;
    end else begin
      if (cmd.commit && target) begin
        active_r <= 1'b1;
      end
      if (cmd.open) begin
        match_r <= 1'b1;
      end else if (cmd.cmp && active_r && miss) begin
        match_r <= 1'b0;
      end
    end
  end

endmodule

/* design/nlsc_parser.sv */
// ----------------------------------------------------------------------------
// nlsc_parser
// Syntax state machine: phase, first error, name length and flags, name
// count. Drives the cell row and forms the result word of each input word.
// ----------------------------------------------------------------------------
module nlsc_parser #(
  parameter int MAX_NAMES = 16,
  parameter int MAX_NAME_LEN = 32,
  parameter int LW = 6,
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  nlsc_pkg::in_word_t   in_word,
  input  logic                 dup,
  output nlsc_pkg::cell_cmd_t  cmd,
  output logic [LW-1:0]        cur_len,
  output logic [LW-1:0]        rd_len,
  output nlsc_pkg::out_word_t  res
);
  import nlsc_pkg::*;

  phase_t        phase_r, phase_nxt;
  logic [3:0]    err_r, err_nxt, err_fin;
  logic          seen_r, seen_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          bad_r, bad_nxt;
  logic          dash_r, dash_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ev_open, ev_cmp, ev_commit, ev_clear;
  logic [7:0]    c;
  logic          blank;

  assign c     = in_word.ch;
  assign blank = c inside {CH_SPACE, CH_TAB};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    seen_nxt  = seen_r;
    len_nxt   = len_r;
    bad_nxt   = bad_r;
    dash_nxt  = dash_r;
    count_nxt = count_r;
    ev_open   = 1'b0;
    ev_cmp    = 1'b0;
    ev_commit = 1'b0;
    ev_clear  = 1'b0;
    err_fin   = err_r;
    if (fire && in_word.has_char) begin
      seen_nxt = 1'b1;
      if (err_r == ERR_NONE) begin
        case (phase_r)
          PH_PRE: begin
            if (c == CH_LBRACKET) phase_nxt = PH_OPEN;
            else if (!blank) err_nxt = ERR_NO_OPEN;
          end
          PH_OPEN, PH_QUOTE: begin
            if (phase_r == PH_OPEN && c == CH_RBRACKET) phase_nxt = PH_TAIL;
            else if (c == CH_QUOTE) ev_open = 1'b1;
            else if (!blank) err_nxt = ERR_NO_QUOTE;
          end
          PH_NAME: begin
            if (c == CH_QUOTE) begin
              if (len_r == '0 || bad_r || dash_r) err_nxt = ERR_BAD_NAME;
              else if (dup) err_nxt = ERR_DUPLICATE;
              else if (count_r >= CW'(MAX_NAMES)) err_nxt = ERR_OVERFLOW;
              else begin
                ev_commit = 1'b1;
                count_nxt = count_r + CW'(1);
                phase_nxt = PH_AFTER;
              end
            end else if (len_r >= LW'(MAX_NAME_LEN)) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              ev_cmp  = 1'b1;
              len_nxt = len_r + LW'(1);
              if (c == CH_DASH) begin
                if (len_r == '0 || dash_r) bad_nxt = 1'b1;
                dash_nxt = 1'b1;
              end else if (c inside {[8'h61:8'h7a], [8'h30:8'h39]}) begin
                dash_nxt = 1'b0;
              end else begin
                bad_nxt = 1'b1;
              end
            end
          end
          PH_AFTER: begin
            if (c == CH_COMMA) phase_nxt = PH_QUOTE;
            else if (c == CH_RBRACKET) phase_nxt = PH_TAIL;
            else if (!blank) err_nxt = ERR_NO_SEP;
          end
          default: begin
            if (!blank) err_nxt = ERR_TRAILING;
          end
        endcase
      end
    end
    if (ev_open) begin
      len_nxt   = '0;
      bad_nxt   = 1'b0;
      dash_nxt  = 1'b0;
      phase_nxt = PH_NAME;
    end
    err_fin = err_nxt;
    if (fire && in_word.last) begin
      if (err_nxt == ERR_NONE) begin
        if (!seen_nxt) err_fin = ERR_EMPTY;
        else begin
          case (phase_nxt)
            PH_PRE:            err_fin = ERR_NO_OPEN;
            PH_OPEN, PH_QUOTE: err_fin = ERR_NO_QUOTE;
            PH_NAME:           err_fin = ERR_UNCLOSED;
            PH_AFTER:          err_fin = ERR_NO_SEP;
            default:           err_fin = ERR_NONE;
          endcase
        end
      end
      ev_clear = 1'b1;
    end
  end

  // outputs
  always_comb begin
    cmd.clear  = ev_clear;
    cmd.open   = ev_open;
    cmd.cmp    = ev_cmp;
    cmd.commit = ev_commit;
    cmd.ch     = c;
    cur_len    = len_r;
    rd_len     = ev_clear ? '0 : len_nxt;
    res.done_res   = in_word.last;
    res.accepted   = in_word.last && (err_fin == ERR_NONE);
    res.error_code = err_fin;
    res.name_count = 5'(count_nxt);
    res.name_done  = ev_commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ev_clear) begin
      phase_r <= PH_PRE;
      err_r   <= ERR_NONE;
      seen_r  <= 1'b0;
      len_r   <= '0;
      bad_r   <= 1'b0;
      dash_r  <= 1'b0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      seen_r  <= seen_nxt;
      len_r   <= len_nxt;
      bad_r   <= bad_nxt;
      dash_r  <= dash_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* design/name_list_schema_checker.sv */
// ----------------------------------------------------------------------------
// name_list_schema_checker
// Streaming checker for a bracketed list of quoted, unique names.
//
//   channel | ports                             | word
//   --------+-----------------------------------+-----------------------
//   input   | in_valid, in_ready, in_data       | byte, has_char, last
//   result  | out_valid, out_ready, out_data    | verdict and status
//
// one byte per cycle: the parser step and the parallel compare in every name
// cell finish in the accepting cycle; the result appears in the next cycle in
// the output register. each cell reads its byte memory one position ahead.
// reset is synchronous and needs no clearing pass; an end word clears all.
// with out_valid high and out_ready low the output register holds and in_ready drops.
// ----------------------------------------------------------------------------
module name_list_schema_checker #(
  parameter int MAX_NAMES = 16,
  parameter int MAX_NAME_LEN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nlsc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nlsc_pkg::out_word_t out_data
);
  import nlsc_pkg::*;

  localparam int LW = $clog2(MAX_NAME_LEN + 1);
  localparam int CW = $clog2(MAX_NAMES + 1);

  logic          fire;
  logic          out_valid_r;
  out_word_t     out_data_r;
  out_word_t     res;
  cell_cmd_t     cmd;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] rd_len;
  logic [MAX_NAMES:0] act_chain;
  logic [MAX_NAMES:0] dup_chain;

  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  nlsc_parser #(
    .MAX_NAMES    (MAX_NAMES),
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .LW           (LW),
    .CW           (CW)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_word (in_data),
    .dup     (dup_chain[MAX_NAMES]),
    .cmd     (cmd),
    .cur_len (cur_len),
    .rd_len  (rd_len),
    .res     (res)
  );

  assign act_chain[0] = 1'b1;
  assign dup_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_NAMES; i++) begin : g_cell
    nlsc_cell #(
      .MAX_NAME_LEN (MAX_NAME_LEN),
      .LW           (LW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .cur_len     (cur_len),
      .rd_len      (rd_len),
      .prev_active (act_chain[i]),
      .active_out  (act_chain[i+1]),
      .dup_in      (dup_chain[i]),
      .dup_out     (dup_chain[i+1])
    );
  end

  // output word register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
